// ----- rtl/core/dfr_pkg.sv -----
// dfr_pkg: shared types and constants of the two format packet deframer
// holds the marker codes, status codes and the result word layout
// no dependencies
package dfr_pkg;

   // frame marker bytes
   localparam logic [7:0] MARK_SHORT = 8'hC1;
   localparam logic [7:0] MARK_LONG  = 8'hC2;

   // opcode position and shortest legal length for each format
   localparam logic [16:0] OPC_POS_SHORT = 17'd3;
   localparam logic [16:0] OPC_POS_LONG  = 17'd4;
   localparam logic [16:0] MIN_LEN_SHORT = 17'd4;
   localparam logic [16:0] MIN_LEN_LONG  = 17'd5;

   // field widths of the result word
   localparam int unsigned OFS_W = 13;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_MARKER = 2'd1,
      STAT_BAD_LENGTH = 2'd2,
      STAT_CLOSED     = 2'd3
   } status_type;

   // one result word
   typedef struct packed {
      logic [7:0]       data_byte;
      logic [OFS_W-1:0] byte_offset;
      logic             frame_last;
      logic [7:0]       frame_opcode;
      logic [OFS_W-1:0] frame_length;
      logic             long_format;
      status_type       status;
   } rsp_type;

endpackage

// ----- rtl/core/dfr_track.sv -----
// dfr_track: frame tracking state and per-byte decode
// keeps offset, length, format, opcode and link-closed state; builds one result word per byte
// depends on dfr_pkg
module dfr_track
   import dfr_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = 8192
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output rsp_type    result,
   output logic       closed
);

   localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);
   localparam logic [16:0] BUF_LEN = 17'(BUFFER_BYTES);

   logic [CNT_W-1:0] offset_ff, offset_in;
   logic [15:0]      length_ff, length_in;
   logic             format_ff, format_in;
   logic [7:0]       opcode_ff, opcode_in;
   logic             closed_ff, closed_in;

   logic [16:0] pos_ext;
   logic [15:0] len_now;
   logic [7:0]  op_now;
   logic        check;
   logic [16:0] min_len;
   logic [16:0] opc_pos;

   assign pos_ext = 17'(offset_ff);
   assign min_len = format_ff ? MIN_LEN_LONG : MIN_LEN_SHORT;
   assign opc_pos = format_ff ? OPC_POS_LONG : OPC_POS_SHORT;
   assign closed  = closed_ff;

   // decode of one byte against the current frame state
   always_comb begin
      offset_in = offset_ff;
      length_in = length_ff;
      format_in = format_ff;
      opcode_in = opcode_ff;
      closed_in = closed_ff;
      len_now   = length_ff;
      op_now    = opcode_ff;
      check     = 1'b0;

      result.data_byte    = rx_byte;
      result.byte_offset  = pos_ext[OFS_W-1:0];
      result.frame_last   = 1'b0;
      result.frame_opcode = 8'h00;
      result.frame_length = '0;
      result.long_format  = format_ff;
      result.status       = STAT_OK;

      if (closed_ff) begin
         // link closed: drop everything
         result.byte_offset = '0;
         result.long_format = 1'b0;
         result.status      = STAT_CLOSED;
      end else if (offset_ff == '0) begin
         // marker expected
         if (rx_byte == MARK_SHORT || rx_byte == MARK_LONG) begin
            format_in          = (rx_byte == MARK_LONG);
            result.long_format = (rx_byte == MARK_LONG);
            length_in          = 16'h0000;
            opcode_in          = 8'h00;
            offset_in          = CNT_W'(1);
         end else begin
            result.long_format = 1'b0;
            result.status      = STAT_BAD_MARKER;
            closed_in          = 1'b1;
            offset_in          = '0;
         end
      end else begin
         // length bytes
         if (pos_ext == 17'd1) begin
            if (format_ff) begin
               len_now = {rx_byte, 8'h00};
            end else begin
               len_now = {8'h00, rx_byte};
               check   = 1'b1;
            end
         end else if (pos_ext == 17'd2 && format_ff) begin
            len_now = {length_ff[15:8], rx_byte};
            check   = 1'b1;
         end
         length_in = len_now;

         if (check && (17'(len_now) < min_len || 17'(len_now) >= BUF_LEN)) begin
            result.status = STAT_BAD_LENGTH;
            closed_in     = 1'b1;
            offset_in     = '0;
         end else begin
            // opcode capture, reported at once if it is also the last byte
            op_now    = (pos_ext == opc_pos) ? rx_byte : opcode_ff;
            opcode_in = op_now;
            if (pos_ext >= 17'd3 && (pos_ext + 17'd1) >= 17'(len_now)) begin
               result.frame_last   = 1'b1;
               result.frame_opcode = op_now;
               result.frame_length = len_now[OFS_W-1:0];
               offset_in           = '0;
            end else begin
               offset_in = CNT_W'(pos_ext + 17'd1);
            end
         end
      end
   end

   // frame state, advanced on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         length_ff <= '0;
         format_ff <= 1'b0;
         opcode_ff <= '0;
         closed_ff <= 1'b0;
      end else if (accept) begin
         offset_ff <= offset_in;
         length_ff <= length_in;
         format_ff <= format_in;
         opcode_ff <= opcode_in;
         closed_ff <= closed_in;
      end
   end

endmodule

// ----- rtl/core/dfr_out_reg.sv -----
// dfr_out_reg: result register between the decode and the result channel
// holds one result word and its valid flag, stalls the input only while full and stalled
// depends on dfr_pkg
module dfr_out_reg
   import dfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  rsp_type in_word,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_word
);

   logic    valid_ff, valid_in;
   rsp_type word_ff;
   logic    load;

   assign in_stall  = valid_ff && out_stall;
   assign load      = in_valid && !in_stall;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // full when loaded, empty once taken with nothing new behind it
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!out_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= in_word;
      end
   end

endmodule

// ----- rtl/core/two_format_packet_deframer.sv -----
// two_format_packet_deframer: top level of the byte stream deframer
// ties the frame tracker to the result register
// depends on dfr_pkg, dfr_track and dfr_out_reg
//
// Takes one received byte per word on the req_ channel and returns one result word per byte
// on the rsp_ channel, in the cycle after the byte is taken. A frame opens with 0xC1 (one-byte
// length, opcode at offset 3) or 0xC2 (two-byte big-endian length, opcode at offset 4); the
// length counts every byte of the frame including the marker. Every byte comes back with its
// offset; the final byte also carries the opcode and total length. A bad marker, or a length
// below the opcode reach or not below BUFFER_BYTES, is flagged once and then every byte is
// returned with status closed until reset. The block takes a byte every cycle while req_stall is
// low: the per-byte decode is one short compare-and-count step, and the single result register
// lets a new byte in while the previous result is being taken; req_stall is high only when
// that register is full and rsp_stall is high.
module two_format_packet_deframer
   import dfr_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic [12:0] rsp_byte_offset,
   output logic        rsp_frame_last,
   output logic [7:0]  rsp_frame_opcode,
   output logic [12:0] rsp_frame_length,
   output logic        rsp_long_format,
   output logic [1:0]  rsp_status
);

   rsp_type dec_word;
   rsp_type out_word;
   logic    accept;
   logic    link_closed;

   assign accept = req_valid && !req_stall;

   // per-byte decode and frame state
   dfr_track #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_track (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .result  (dec_word),
      .closed  (link_closed)
   );

   // result register
   dfr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (dec_word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   // result fields
   assign rsp_data_byte    = out_word.data_byte;
   assign rsp_byte_offset  = out_word.byte_offset;
   assign rsp_frame_last   = out_word.frame_last;
   assign rsp_frame_opcode = out_word.frame_opcode;
   assign rsp_frame_length = out_word.frame_length;
   assign rsp_long_format  = out_word.long_format;
   assign rsp_status       = out_word.status;

   // a frame end is only ever reported on a good byte
   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_status == STAT_OK)
      else $error("frame end with error status");

   // a reported error has closed the link
   a_err_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_BAD_MARKER || rsp_status == STAT_BAD_LENGTH)
      |-> link_closed)
      else $error("error reported but link still open");

   // dropped bytes carry no frame information
   a_closed_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_CLOSED
      |-> rsp_byte_offset == 13'd0 && !rsp_long_format && !rsp_frame_last)
      else $error("dropped byte carries frame fields");

   // input held back only while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

endmodule

// ----- tb/sv/dfr_frame_checker.sv -----
// dfr_frame_checker: watches both channels of the deframer, predicts each result word
// and compares it field by field with the word the block returns
// depends on dfr_pkg
module dfr_frame_checker
   import dfr_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_data_byte,
   input  logic [12:0] rsp_byte_offset,
   input  logic        rsp_frame_last,
   input  logic [7:0]  rsp_frame_opcode,
   input  logic [12:0] rsp_frame_length,
   input  logic        rsp_long_format,
   input  logic [1:0]  rsp_status,
   output int          fault_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the frame tracker
   logic [16:0] next_offset;
   logic [15:0] frame_len;
   logic        long_frame;
   logic [7:0]  held_opcode;
   logic        link_closed;

   // result words still owed by the block, oldest first
   rsp_type expected_words[$];
   rsp_type got_word;
   rsp_type want_word;

   initial begin
      fault_count   = 0;
      pending_words = 0;
   end

   // advance the shadow tracker by one byte and work out its result word
   task automatic deframe_byte(input logic [7:0] rx, output rsp_type w);
      logic [16:0] pos;
      logic [16:0] min_len;
      logic [16:0] opc_pos;
      logic        len_known;
      w             = '0;
      w.data_byte   = rx;
      w.long_format = long_frame;
      w.status      = STAT_OK;
      pos           = next_offset;
      w.byte_offset = pos[12:0];
      len_known     = 1'b0;
      if (link_closed) begin
         // everything dropped until reset
         w.byte_offset = '0;
         w.long_format = 1'b0;
         w.status      = STAT_CLOSED;
      end else if (pos == '0) begin
         if (rx == MARK_SHORT || rx == MARK_LONG) begin
            long_frame    = (rx == MARK_LONG);
            w.long_format = long_frame;
            frame_len     = '0;
            held_opcode   = '0;
            next_offset   = 17'd1;
         end else begin
            w.long_format = 1'b0;
            w.status      = STAT_BAD_MARKER;
            link_closed   = 1'b1;
            next_offset   = '0;
         end
      end else begin
         // length capture, one or two bytes big-endian
         if (pos == 17'd1) begin
            if (long_frame) begin
               frame_len = {rx, 8'h00};
            end else begin
               frame_len = {8'h00, rx};
               len_known = 1'b1;
            end
         end else if (pos == 17'd2 && long_frame) begin
            frame_len[7:0] = rx;
            len_known      = 1'b1;
         end
         if (len_known) begin
            min_len = long_frame ? MIN_LEN_LONG : MIN_LEN_SHORT;
            if ({1'b0, frame_len} < min_len || frame_len >= BUFFER_BYTES) begin
               w.status    = STAT_BAD_LENGTH;
               link_closed = 1'b1;
               next_offset = '0;
            end
         end
         if (w.status == STAT_OK) begin
            opc_pos = long_frame ? OPC_POS_LONG : OPC_POS_SHORT;
            if (pos == opc_pos) held_opcode = rx;
            // the opcode byte may itself close the frame
            if (pos >= OPC_POS_SHORT && pos + 17'd1 >= {1'b0, frame_len}) begin
               w.frame_last   = 1'b1;
               w.frame_opcode = held_opcode;
               w.frame_length = frame_len[12:0];
               next_offset    = '0;
            end else begin
               next_offset = pos + 17'd1;
            end
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fault_count++;
      end
   endtask

   // result words are compared before the byte taken at the same edge is queued
   always @(posedge clock) begin
      if (reset) begin
         next_offset = '0;
         frame_len   = '0;
         long_frame  = 1'b0;
         held_opcode = '0;
         link_closed = 1'b0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_word.data_byte    = rsp_data_byte;
            got_word.byte_offset  = rsp_byte_offset;
            got_word.frame_last   = rsp_frame_last;
            got_word.frame_opcode = rsp_frame_opcode;
            got_word.frame_length = rsp_frame_length;
            got_word.long_format  = rsp_long_format;
            got_word.status       = status_type'(rsp_status);
            if (expected_words.size() == 0) begin
               $error("result word with data_byte %0d arrived with no byte outstanding",
                      rsp_data_byte);
               fault_count++;
            end else begin
               want_word = expected_words.pop_front();
               check_field("data_byte", want_word.data_byte, got_word.data_byte);
               check_field("byte_offset", want_word.byte_offset, got_word.byte_offset);
               check_field("frame_last", want_word.frame_last, got_word.frame_last);
               check_field("frame_opcode", want_word.frame_opcode, got_word.frame_opcode);
               check_field("frame_length", want_word.frame_length, got_word.frame_length);
               check_field("long_format", want_word.long_format, got_word.long_format);
               check_field("status", want_word.status, got_word.status);
            end
         end
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte, want_word);
            expected_words.push_back(want_word);
         end
      end
      pending_words = expected_words.size();
   end

endmodule

// ----- tb/sv/two_format_packet_deframer_test.sv -----
// two_format_packet_deframer_test: drives framed byte streams into the deframer under
// varying idle patterns and gives the verdict
// depends on dfr_pkg, two_format_packet_deframer and dfr_frame_checker
module two_format_packet_deframer_test
   import dfr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BUFFER_BYTES = 8192;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned PHASE_BYTES  = 300;
   localparam int unsigned HOLD_CYCLES  = 64;
   localparam int unsigned CLOSED_BYTES = 30;
   localparam int unsigned DRAIN_CYCLES = 10;

   // ways of closing the link at the end of the run
   typedef enum int {
      BREAK_MARKER,
      BREAK_SHORT_ZERO,
      BREAK_SHORT_LOW,
      BREAK_LONG_LOW,
      BREAK_LONG_HIGH
   } break_kind_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_data_byte;
   logic [12:0] rsp_byte_offset;
   logic        rsp_frame_last;
   logic [7:0]  rsp_frame_opcode;
   logic [12:0] rsp_frame_length;
   logic        rsp_long_format;
   logic [1:0]  rsp_status;

   int          fault_count;
   int          pending_words;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bit          hold_off_go    = 1'b0;
   int unsigned cycle_count    = 0;

   // short frames with the opcode on the last byte, extreme bytes, markers as payload
   logic [7:0] directed_bytes[22] = '{
      MARK_SHORT, 8'h04, 8'h00, 8'hFF,
      MARK_LONG,  8'h00, 8'h05, 8'hFF, 8'h00,
      MARK_SHORT, 8'h06, 8'hFF, 8'h5A, 8'h00, 8'hFF,
      MARK_SHORT, 8'h07, 8'h33, 8'hA5, MARK_SHORT, MARK_LONG, 8'h80
   };

   two_format_packet_deframer #(.BUFFER_BYTES(BUFFER_BYTES)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_frame_length (rsp_frame_length),
      .rsp_long_format  (rsp_long_format),
      .rsp_status       (rsp_status)
   );

   dfr_frame_checker #(.BUFFER_BYTES(BUFFER_BYTES)) frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_frame_length (rsp_frame_length),
      .rsp_long_format  (rsp_long_format),
      .rsp_status       (rsp_status),
      .fault_count      (fault_count),
      .pending_words    (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            hold_left   = HOLD_CYCLES;
            hold_off_go = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // offer one word, with random idle cycles first, and wait until it is taken
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and wait until every result word has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_words == 0);
   endtask

   // one well-formed frame with random opcode and payload
   task automatic send_frame(input bit long_fmt, input int unsigned len);
      logic [7:0]  opc;
      logic [7:0]  b;
      int unsigned i;
      opc = 8'($urandom_range(255));
      for (i = 0; i < len; i++) begin
         if (i == 0) b = long_fmt ? MARK_LONG : MARK_SHORT;
         else if (i == 1) b = long_fmt ? len[15:8] : len[7:0];
         else if (i == 2 && long_fmt) b = len[7:0];
         else if (i == (long_fmt ? OPC_POS_LONG : OPC_POS_SHORT)) b = opc;
         else b = 8'($urandom_range(255));
         send_byte(b);
      end
   endtask

   // frames of random format, short or long with even odds
   task automatic run_phase(input int s_pct, input int r_pct, input int unsigned budget);
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      bit          long_fmt;
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      sent           = 0;
      while (sent < budget) begin
         long_fmt = 1'($urandom_range(1));
         pick     = $urandom_range(99);
         if (!long_fmt) begin
            if (pick < 75) len = $urandom_range(12, MIN_LEN_SHORT);
            else if (pick < 95) len = $urandom_range(64, 13);
            else len = $urandom_range(255, 65);
         end else begin
            if (pick < 65) len = $urandom_range(16, MIN_LEN_LONG);
            else if (pick < 90) len = $urandom_range(64, 17);
            else if (pick < 97) len = $urandom_range(255, 65);
            else len = $urandom_range(600, 256);
         end
         send_frame(long_fmt, len);
         sent += len;
      end
   endtask

   // close the link in one of the ways it can fail, then feed it bytes to drop
   task automatic break_link();
      break_kind_type kind;
      logic [7:0]     b;
      int unsigned    i;
      kind = break_kind_type'($urandom_range(BREAK_LONG_HIGH));
      case (kind)
         BREAK_MARKER: begin
            do b = 8'($urandom_range(255)); while (b == MARK_SHORT || b == MARK_LONG);
            send_byte(b);
         end
         BREAK_SHORT_ZERO: begin
            send_byte(MARK_SHORT);
            send_byte(8'h00);
         end
         BREAK_SHORT_LOW: begin
            send_byte(MARK_SHORT);
            send_byte(8'($urandom_range(MIN_LEN_SHORT - 1, 1)));
         end
         BREAK_LONG_LOW: begin
            send_byte(MARK_LONG);
            send_byte(8'h00);
            send_byte(8'($urandom_range(MIN_LEN_LONG - 1, 0)));
         end
         default: begin
            send_byte(MARK_LONG);
            send_byte(8'($urandom_range(255, BUFFER_BYTES >> 8)));
            send_byte(8'($urandom_range(255)));
         end
      endcase
      for (i = 0; i < CLOSED_BYTES; i++) begin
         if ($urandom_range(3) == 0) b = $urandom_range(1) ? MARK_LONG : MARK_SHORT;
         else b = 8'($urandom_range(255));
         send_byte(b);
      end
   endtask

   // stimulus and verdict
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames, no idling
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      run_phase(38, 80, PHASE_BYTES);
      drain_results();
      run_phase(80, 38, PHASE_BYTES);
      drain_results();

      // no idling; the receiver holds off while the sender keeps offering
      hold_off_go = 1'b1;
      run_phase(0, 0, PHASE_BYTES);
      // largest legal one-byte-length frame
      send_frame(1'b0, 255);
      drain_results();

      send_idle_pct  = 20;
      recv_stall_pct = 20;
      break_link();
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && pending_words == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- two_format_packet_deframer.f -----
rtl/core/dfr_pkg.sv
rtl/core/dfr_track.sv
rtl/core/dfr_out_reg.sv
rtl/core/two_format_packet_deframer.sv
tb/sv/dfr_frame_checker.sv
tb/sv/two_format_packet_deframer_test.sv
